// File: src/qavg_pkg.sv
// Package: shared types and constants of the quaternion averaging block.
`timescale 1ns / 1ps
`default_nettype none
package qavg_pkg;
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MSHIFT,
        S_MAPPLY,
        S_MUL,
        S_VFIT,
        S_VNORM,
        S_KSUM,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    // Which two components form each of the ten distinct products.
    function automatic logic [1:0] pair_a(input logic [3:0] i);
        case (i)
            4'd0, 4'd1, 4'd2, 4'd3: pair_a = 2'd0;
            4'd4, 4'd5, 4'd6:       pair_a = 2'd1;
            4'd7, 4'd8:             pair_a = 2'd2;
            default:                pair_a = 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] pair_b(input logic [3:0] i);
        case (i)
            4'd0:                   pair_b = 2'd0;
            4'd1, 4'd4:             pair_b = 2'd1;
            4'd2, 4'd5, 4'd7:       pair_b = 2'd2;
            default:                pair_b = 2'd3;
        endcase
    endfunction

    // Symmetric matrix entry (row, col) to sum index.
    function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
        logic [1:0] lo;
        logic [1:0] hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        case (lo)
            2'd0:    mat_idx = {2'b00, hi};
            2'd1:    mat_idx = 4'd3 + {2'b00, hi};
            2'd2:    mat_idx = 4'd5 + {2'b00, hi};
            default: mat_idx = 4'd9;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: src/quaternion_average.sv
// Top level: batch quaternion averaging by power iteration on the normal matrix.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | handshake          | payload
//  in      | request   | i_valid / o_stall  | i_quat_x..w, i_last_in_batch
//  out     | result    | o_valid / i_stall  | o_avg_x..w, o_degenerate
//
// One shared 32x17 signed multiplier does every product, one per cycle.
// A plain item takes its request cycle and then its 10 products.
// The item marked last adds the matrix fit (a right shift of up to 16 bits),
// POWER_STEPS times 16 products plus fit and renormalize steps, then, unless the
// norm sum is zero, 4 divisions of 64 quotient bits and 4 square roots of 16 bits.
// Synchronous active-low reset clears state, batch sums, start vector and o_valid.
// The result is held in an output register until taken; the next batch runs
// meanwhile, and a new result waits in the output state until that register frees.
module quaternion_average #(
    parameter int POWER_STEPS = 6
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [15:0]  i_quat_x,
    input  wire signed [15:0]  i_quat_y,
    input  wire signed [15:0]  i_quat_z,
    input  wire signed [15:0]  i_quat_w,
    input  wire                i_last_in_batch,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_avg_x,
    output logic signed [15:0] o_avg_y,
    output logic signed [15:0] o_avg_z,
    output logic signed [15:0] o_avg_w,
    output logic               o_degenerate
);
    localparam int SW = (POWER_STEPS > 1) ? $clog2(POWER_STEPS) : 1;

    qavg_pkg::t_state r_state, n_state;

    logic signed [47:0] r_sum [10];
    logic signed [31:0] r_m   [10];
    logic signed [15:0] r_sv  [4];
    logic signed [16:0] r_v   [4];
    logic signed [63:0] r_t   [4];
    logic signed [15:0] r_q   [4];
    logic               r_first, r_last;
    logic [3:0]         r_idx;
    logic [1:0]         r_row, r_col;
    logic [SW-1:0]      r_step;
    logic [5:0]         r_sh;
    logic [63:0]        r_k;
    logic [63:0]        r_num, r_quo;
    logic [64:0]        r_rem;
    logic [6:0]         r_cnt;
    logic [15:0]        r_a;
    logic [15:0]        r_res [4];
    logic [15:0]        r_ores [4];
    logic               r_ovalid, r_deg;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != qavg_pkg::S_IDLE);

    // fit checks
    logic m_fit, t_fit;
    logic [15:0] big;
    always_comb begin
        m_fit = 1'b1;
        for (int i = 0; i < 10; i++)
            if ((r_sum[i] >>> r_sh) > 48'sh7FFF_FFFF || (r_sum[i] >>> r_sh) < -48'sh8000_0000)
                m_fit = 1'b0;
        t_fit = 1'b1;
        for (int i = 0; i < 4; i++)
            if ((r_t[i] >>> r_sh) > 64'sd32767 || (r_t[i] >>> r_sh) < -64'sd32767)
                t_fit = 1'b0;
        big = '0;
        for (int i = 0; i < 4; i++)
            if (16'(r_v[i] < 0 ? -r_v[i] : r_v[i]) > big)
                big = 16'(r_v[i] < 0 ? -r_v[i] : r_v[i]);
    end

    logic [15:0] vmag;
    logic [16:0] cand;
    logic [33:0] odd;
    // magnitude of the first component; its square is the first division's numerator
    assign vmag = 16'(r_v[0] < 0 ? -r_v[0] : r_v[0]);
    assign cand = {1'b0, r_a} + (17'd1 << r_cnt[3:0]);
    assign odd  = {cand, 1'b0} - 34'd1;
    logic [64:0] rem_sh;
    assign rem_sh = {r_rem[63:0], r_num[63]};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            qavg_pkg::S_ACC: begin
                mul_a = 32'(r_q[qavg_pkg::pair_a(r_idx)]);
                mul_b = 17'(r_q[qavg_pkg::pair_b(r_idx)]);
            end
            qavg_pkg::S_MUL: begin
                mul_a = r_m[qavg_pkg::mat_idx(r_row, r_col)];
                mul_b = r_v[r_col];
            end
            qavg_pkg::S_KSUM: begin
                mul_a = 32'(r_v[r_row]);
                mul_b = r_v[r_row];
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qavg_pkg::S_IDLE:   if (accept) n_state = qavg_pkg::S_ACC;
            qavg_pkg::S_ACC:    if (r_idx == 4'd9)
                                    n_state = r_last ? qavg_pkg::S_MSHIFT : qavg_pkg::S_IDLE;
            qavg_pkg::S_MSHIFT: if (m_fit) n_state = qavg_pkg::S_MAPPLY;
            qavg_pkg::S_MAPPLY: n_state = qavg_pkg::S_MUL;
            qavg_pkg::S_MUL:    if (r_row == 2'd3 && r_col == 2'd3) n_state = qavg_pkg::S_VFIT;
            qavg_pkg::S_VFIT:   if (t_fit) n_state = qavg_pkg::S_VNORM;
            qavg_pkg::S_VNORM:  if (big == 0 || big >= 16'd16384)
                                    n_state = (r_step == SW'(POWER_STEPS - 1))
                                        ? qavg_pkg::S_KSUM : qavg_pkg::S_MUL;
            qavg_pkg::S_KSUM:   if (r_row == 2'd3) n_state = qavg_pkg::S_DIV;
            qavg_pkg::S_DIV:    if (r_k == 0) n_state = qavg_pkg::S_OUT;
                                else if (r_cnt == 7'd63) n_state = qavg_pkg::S_SQRT;
            qavg_pkg::S_SQRT:   if (r_cnt == 7'd0)
                                    n_state = (r_row == 2'd3) ? qavg_pkg::S_OUT : qavg_pkg::S_DIV;
            // hold until the output register is free or being taken
            qavg_pkg::S_OUT:    if (!r_ovalid || !i_stall) n_state = qavg_pkg::S_IDLE;
            default:            n_state = qavg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= qavg_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < 10; i++) r_sum[i] <= '0;
            for (int i = 0; i < 4; i++) r_sv[i] <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                qavg_pkg::S_IDLE: if (accept) begin
                    // capture request; first of batch becomes start vector
                    r_q[0] <= i_quat_x; r_q[1] <= i_quat_y;
                    r_q[2] <= i_quat_z; r_q[3] <= i_quat_w;
                    r_last <= i_last_in_batch;
                    r_idx  <= '0;
                    if (!r_first) begin
                        r_sv[0] <= i_quat_x; r_sv[1] <= i_quat_y;
                        r_sv[2] <= i_quat_z; r_sv[3] <= i_quat_w;
                        r_first <= 1'b1;
                    end
                end
                qavg_pkg::S_ACC: begin
                    logic signed [48:0] s;
                    s = 49'(r_sum[r_idx]) + mul_p;
                    if (s > 49'(qavg_pkg::SUM_MAX))      r_sum[r_idx] <= qavg_pkg::SUM_MAX;
                    else if (s < 49'(qavg_pkg::SUM_MIN)) r_sum[r_idx] <= qavg_pkg::SUM_MIN;
                    else                                r_sum[r_idx] <= 48'(s);
                    r_idx <= r_idx + 4'd1;
                    r_sh  <= '0;
                end
                qavg_pkg::S_MSHIFT: if (!m_fit) r_sh <= r_sh + 6'd1;
                qavg_pkg::S_MAPPLY: begin
                    for (int i = 0; i < 10; i++) r_m[i] <= 32'(r_sum[i] >>> r_sh);
                    for (int i = 0; i < 4; i++) begin
                        r_v[i] <= 17'(r_sv[i]);
                        r_t[i] <= '0;
                    end
                    r_row <= '0; r_col <= '0; r_step <= '0;
                end
                qavg_pkg::S_MUL: begin
                    r_t[r_row] <= r_t[r_row] + 64'(mul_p);
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) r_row <= r_row + 2'd1;
                    r_sh <= '0;
                end
                qavg_pkg::S_VFIT: if (t_fit) begin
                    for (int i = 0; i < 4; i++) r_v[i] <= 17'(r_t[i] >>> r_sh);
                end else r_sh <= r_sh + 6'd1;
                qavg_pkg::S_VNORM: begin
                    if (big != 0 && big < 16'd16384) begin
                        for (int i = 0; i < 4; i++) r_v[i] <= r_v[i] <<< 1;
                    end else begin
                        // advance to next iteration, or set up norm sum
                        r_step <= r_step + SW'(1);
                        for (int i = 0; i < 4; i++) r_t[i] <= '0;
                        r_row <= '0; r_col <= '0; r_k <= '0;
                    end
                end
                qavg_pkg::S_KSUM: begin
                    r_k   <= r_k + 64'(mul_p);
                    r_row <= r_row + 2'd1;
                    if (r_row == 2'd3) begin
                        r_row <= '0;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_num <= {32'(vmag) * 32'(vmag), 32'd0};
                    end
                end
                qavg_pkg::S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (rem_sh >= {1'b0, r_k}) begin
                        r_rem <= rem_sh - {1'b0, r_k};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_cnt <= 7'd15;
                        r_a   <= '0;
                    end
                end
                qavg_pkg::S_SQRT: begin
                    logic [15:0] a2;
                    a2 = r_a;
                    if (cand <= 17'd32768 && 68'(odd) * 68'(odd) <= 68'(r_quo))
                        a2 = (cand > 17'd32767) ? 16'd32767 : cand[15:0];
                    r_a <= a2;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        r_res[r_row] <= (r_v[r_row] < 0) ? -a2 : a2;
                        r_row <= r_row + 2'd1;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_num <= {32'(16'(r_v[r_row + 2'd1] < 0 ? -r_v[r_row + 2'd1]
                                   : r_v[r_row + 2'd1])) * 32'(16'(r_v[r_row + 2'd1] < 0
                                   ? -r_v[r_row + 2'd1] : r_v[r_row + 2'd1])), 32'd0};
                    end
                end
                qavg_pkg::S_OUT: if (!r_ovalid || !i_stall) begin
                    // hand the result to the output register
                    r_ovalid <= 1'b1;
                    r_deg    <= (r_k == 0);
                    for (int i = 0; i < 4; i++) r_ores[i] <= (r_k == 0) ? '0 : r_res[i];
                    // drop batch state
                    for (int i = 0; i < 10; i++) r_sum[i] <= '0;
                    for (int i = 0; i < 4; i++) r_sv[i] <= '0;
                    r_first <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_avg_x      = r_ores[0];
    assign o_avg_y      = r_ores[1];
    assign o_avg_z      = r_ores[2];
    assign o_avg_w      = r_ores[3];
    assign o_degenerate = r_deg;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != qavg_pkg::S_IDLE) |-> o_stall) else $error("request taken while busy");
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == qavg_pkg::S_OUT)) else $error("stray result");
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> !r_first) else $error("batch state kept");
endmodule
`default_nettype wire
